>>> sv/tswm_pkg.sv
package tswm_pkg;

    localparam int DATA_W         = 32;
    localparam int LIST_DEPTH_DEF = 16;

    // source of a merged element
    typedef enum logic [1:0] {
        SRC_A = 2'd0,
        SRC_B = 2'd1,
        SRC_C = 2'd2
    } src_t;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

endpackage

>>> sv/three_way_sorted_merge.sv
// Three-way merge of sorted lists. Each beat with s_func = 0 appends s_value to list A, B or C
// (s_list_sel 0, 1, 2). It is accepted whenever the block is idle. Loads into a full list are dropped, and
// so are loads with selector 3. A beat with s_func = 1 starts a run. The run streams every
// stored element out in ascending signed order, and m_last marks the final beat. On equal
// values list A goes first, then B, then C. An empty run gives no beats. After a run all
// three lists are empty. The lists are not checked for order. One comparator is shared over
// the two compare steps of each element, and each list store has one read port with a
// registered read. So each element passes through FETCH, CMP1, CMP2 and EMIT, where it waits
// for m_ready, and the block takes no new beat until the last element has been accepted.
module three_way_sorted_merge #(
    parameter int LIST_DEPTH = tswm_pkg::LIST_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [1:0]                          s_list_sel,
    input  logic signed [tswm_pkg::DATA_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tswm_pkg::DATA_W-1:0]  m_merged_value,
    output logic                                m_last
);
    import tswm_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int REM_W = $clog2(3 * LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_CMP1  = 3'd2;
    localparam logic [2:0] ST_CMP2  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] count_a_reg, count_a_next;
    logic [CNT_W-1:0] count_b_reg, count_b_next;
    logic [CNT_W-1:0] count_c_reg, count_c_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [REM_W-1:0] remain_reg, remain_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic best_vld_reg, best_vld_next;
    src_t best_src_reg, best_src_next;
    src_t out_src_reg, out_src_next;
    logic m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_data_reg, m_data_next;
    logic m_last_reg, m_last_next;

    logic signed [DATA_W-1:0] mem_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] mem_b [LIST_DEPTH];
    logic signed [DATA_W-1:0] mem_c [LIST_DEPTH];
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg, rd_c_reg;

    logic s_fire, wr_a, wr_b, wr_c;
    logic va, vb, vc;
    logic signed [DATA_W-1:0] cmp_x, cmp_y;
    logic cmp_xv, cmp_yv, take_x;
    logic [REM_W-1:0] total;

    assign s_ready        = (state_reg == ST_IDLE);
    assign s_fire         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_merged_value = m_data_reg;
    assign m_last         = m_last_reg;

    assign wr_a = s_fire && (s_func == FUNC_LOAD) && (s_list_sel == 2'(SRC_A))
                  && (count_a_reg < FULL);
    assign wr_b = s_fire && (s_func == FUNC_LOAD) && (s_list_sel == 2'(SRC_B))
                  && (count_b_reg < FULL);
    assign wr_c = s_fire && (s_func == FUNC_LOAD) && (s_list_sel == 2'(SRC_C))
                  && (count_c_reg < FULL);

    assign va = (i_reg < count_a_reg);
    assign vb = (j_reg < count_b_reg);
    assign vc = (k_reg < count_c_reg);

    assign total = REM_W'(count_a_reg) + REM_W'(count_b_reg) + REM_W'(count_c_reg);

    // list stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (wr_a) mem_a[count_a_reg[IDX_W-1:0]] <= s_value;
        if (wr_b) mem_b[count_b_reg[IDX_W-1:0]] <= s_value;
        if (wr_c) mem_c[count_c_reg[IDX_W-1:0]] <= s_value;
        rd_a_reg <= mem_a[i_reg[IDX_W-1:0]];
        rd_b_reg <= mem_b[j_reg[IDX_W-1:0]];
        rd_c_reg <= mem_c[k_reg[IDX_W-1:0]];
    end

    // shared compare: a vs b first, then the winner vs c
    always_comb begin
        if (state_reg == ST_CMP2) begin
            cmp_x  = best_val_reg;
            cmp_xv = best_vld_reg;
            cmp_y  = rd_c_reg;
            cmp_yv = vc;
        end else begin
            cmp_x  = rd_a_reg;
            cmp_xv = va;
            cmp_y  = rd_b_reg;
            cmp_yv = vb;
        end
        take_x = cmp_xv && (!cmp_yv || (cmp_x <= cmp_y));
    end

    always_comb begin
        state_next    = state_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        count_c_next  = count_c_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        remain_next   = remain_reg;
        best_val_next = best_val_reg;
        best_vld_next = best_vld_reg;
        best_src_next = best_src_reg;
        out_src_next  = out_src_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        if (wr_a) count_a_next = count_a_reg + 1'b1;
        if (wr_b) count_b_next = count_b_reg + 1'b1;
        if (wr_c) count_c_next = count_c_reg + 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_func == FUNC_RUN)) begin
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    remain_next = total;
                    if (total == '0) begin
                        count_a_next = '0;
                        count_b_next = '0;
                        count_c_next = '0;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // heads are being read into rd_*_reg
                state_next = ST_CMP1;
            end
            ST_CMP1: begin
                best_vld_next = va || vb;
                if (take_x) begin
                    best_val_next = rd_a_reg;
                    best_src_next = SRC_A;
                end else begin
                    best_val_next = rd_b_reg;
                    best_src_next = SRC_B;
                end
                state_next = ST_CMP2;
            end
            ST_CMP2: begin
                if (take_x) begin
                    m_data_next  = best_val_reg;
                    out_src_next = best_src_reg;
                end else begin
                    m_data_next  = rd_c_reg;
                    out_src_next = SRC_C;
                end
                m_valid_next = 1'b1;
                m_last_next  = (remain_reg == REM_W'(1));
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    remain_next  = remain_reg - 1'b1;
                    case (out_src_reg)
                        SRC_A:   i_next = i_reg + 1'b1;
                        SRC_B:   j_next = j_reg + 1'b1;
                        default: k_next = k_reg + 1'b1;
                    endcase
                    if (m_last_reg) begin
                        count_a_next = '0;
                        count_b_next = '0;
                        count_c_next = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            count_c_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            count_c_reg <= count_c_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        remain_reg   <= remain_next;
        best_val_reg <= best_val_next;
        best_vld_reg <= best_vld_next;
        best_src_reg <= best_src_next;
        out_src_reg  <= out_src_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

endmodule

>>> verif/tb_three_way_sorted_merge.sv
`timescale 1ns / 100ps

module tb_three_way_sorted_merge;
    import tswm_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 220;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } merged_beat_t;

    class merge_scoreboard;
        logic signed [DATA_W-1:0] lists [3][DEPTH];
        int                       fill [3];
        merged_beat_t             expected_merge_q [$];
        int                       errors;
        int                       checked;
        int                       loads;
        int                       ignored;
        int                       runs;

        function new();
            fill[0] = 0;
            fill[1] = 0;
            fill[2] = 0;
            errors  = 0;
            checked = 0;
            loads   = 0;
            ignored = 0;
            runs    = 0;
        endfunction

        function int pending();
            return expected_merge_q.size();
        endfunction

        // one accepted input beat: append, or merge the three lists
        function void note_beat(logic func, logic [1:0] sel, logic signed [DATA_W-1:0] value);
            int                       idx [3];
            int                       total;
            int                       src;
            logic                     va, vb, vc;
            logic signed [DATA_W-1:0] a, b, c;
            merged_beat_t             beat;
            if (func == FUNC_LOAD) begin
                if (sel > SRC_C || fill[sel] >= DEPTH) begin
                    ignored++;
                end else begin
                    lists[sel][fill[sel]] = value;
                    fill[sel]++;
                    loads++;
                end
                return;
            end
            runs++;
            idx[0] = 0;
            idx[1] = 0;
            idx[2] = 0;
            total = fill[0] + fill[1] + fill[2];
            for (int n = 0; n < total; n++) begin
                va = idx[0] < fill[0];
                vb = idx[1] < fill[1];
                vc = idx[2] < fill[2];
                a = va ? lists[0][idx[0]] : '0;
                b = vb ? lists[1][idx[1]] : '0;
                c = vc ? lists[2][idx[2]] : '0;
                // ties go to A, then B, then C
                if (va && (!vb || a <= b) && (!vc || a <= c)) begin
                    src = SRC_A;
                end else if (vb && (!vc || b <= c)) begin
                    src = SRC_B;
                end else begin
                    src = SRC_C;
                end
                beat.value = lists[src][idx[src]];
                beat.last  = (n == total - 1);
                idx[src]++;
                expected_merge_q.insert(expected_merge_q.size(), beat);
            end
            fill[0] = 0;
            fill[1] = 0;
            fill[2] = 0;
        endfunction

        function void check_beat(logic signed [DATA_W-1:0] value, logic last);
            merged_beat_t exp_beat;
            if (expected_merge_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected merged beat, expected none, actual value %0d last %0b",
                         $time, value, last);
                return;
            end
            exp_beat = expected_merge_q.pop_front();
            checked++;
            if (value !== exp_beat.value) begin
                errors++;
                $display("%0t: merged_value mismatch, expected %0d actual %0d",
                         $time, exp_beat.value, value);
            end
            if (last !== exp_beat.last) begin
                errors++;
                $display("%0t: last mismatch, expected %0b actual %0b",
                         $time, exp_beat.last, last);
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    logic [1:0]               s_list_sel;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_merged_value;
    logic                     m_last;

    merge_scoreboard sb = new();

    int burst_left = 0;
    int rx_mode    = 0;
    int rx_hold    = 0;
    int cycle_count = 0;
    int drains     = 0;

    three_way_sorted_merge u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_list_sel     (s_list_sel),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_merged_value (m_merged_value),
        .m_last         (m_last)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d merged beats still expected",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check each accepted beat, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat(m_merged_value, m_last);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (rx_hold > 0) begin
                        rx_hold = rx_hold - 1;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    task automatic pause_sender();
        s_valid    <= 1'b0;
        s_func     <= 1'($urandom_range(0, 1));
        s_list_sel <= 2'($urandom_range(0, 3));
        s_value    <= $urandom;
    endtask

    task automatic send_beat(input logic func, input logic [1:0] sel,
                             input logic signed [DATA_W-1:0] value);
        if (burst_left == 0) begin
            pause_sender();
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_list_sel <= sel;
        s_value    <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(func, sel, value);
        burst_left--;
    endtask

    task automatic send_run();
        send_beat(FUNC_RUN, 2'($urandom_range(0, 3)), $urandom);
    endtask

    // hold the sender until every merged beat is back
    task automatic drain_results();
        pause_sender();
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        drains++;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $signed($urandom_range(0, 16)) - 8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // three ascending lists with random content, loads interleaved across lists
    task automatic load_sorted_lists(input int na, input int nb, input int nc);
        logic signed [DATA_W-1:0] vals [3][$];
        int                       len [3];
        int                       idx [3];
        int                       pos;
        int                       l;
        logic signed [DATA_W-1:0] v;
        len[0] = na;
        len[1] = nb;
        len[2] = nc;
        for (int k = 0; k < 3; k++) begin
            idx[k] = 0;
            for (int n = 0; n < len[k]; n++) begin
                v = rand_value();
                pos = 0;
                while (pos < vals[k].size() && vals[k][pos] <= v) pos++;
                vals[k].insert(pos, v);
            end
        end
        while (idx[0] < len[0] || idx[1] < len[1] || idx[2] < len[2]) begin
            l = $urandom_range(0, 2);
            while (idx[l] >= len[l]) l = (l + 1) % 3;
            send_beat(FUNC_LOAD, 2'(l), vals[l][idx[l]]);
            idx[l]++;
        end
        send_run();
    endtask

    // unsorted content, any selector including the unused one
    task automatic load_noise();
        repeat ($urandom_range(2, 10)) begin
            send_beat(FUNC_LOAD, 2'($urandom_range(0, 3)), $urandom);
        end
        send_run();
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(5, DEPTH) : $urandom_range(0, 4);
    endfunction

    initial begin
        aresetn <= 1'b0;
        pause_sender();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty run, extremes with ties, unused selector
        rx_mode = 0;
        send_run();
        send_beat(FUNC_LOAD, SRC_A, 32'sh8000_0000);
        send_beat(FUNC_LOAD, SRC_B, 0);
        send_beat(FUNC_LOAD, SRC_C, -1);
        send_beat(FUNC_LOAD, SRC_A, 0);
        send_beat(FUNC_LOAD, SRC_B, 32'sh7fff_ffff);
        send_beat(FUNC_LOAD, SRC_C, 32'sh7fff_ffff);
        send_beat(FUNC_LOAD, 2'd3, 32'sh5555_5555);
        send_run();
        drain_results();

        // directed: full list drops the extra load
        rx_mode = 2;
        for (int i = 0; i <= DEPTH; i++) begin
            send_beat(FUNC_LOAD, SRC_A, i * 1000 - 8000);
        end
        send_run();
        drain_results();

        while (sb.loads + sb.runs < ITEM_TARGET) begin
            rx_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                7: load_noise();
                8: load_sorted_lists($urandom_range(DEPTH, DEPTH + 4), $urandom_range(0, 2),
                                     $urandom_range(0, 2));
                9: begin
                    load_sorted_lists(pick_len(), pick_len(), pick_len());
                    send_run();
                end
                default: load_sorted_lists(pick_len(), pick_len(), pick_len());
            endcase
            if ($urandom_range(0, 3) == 0) drain_results();
        end

        drain_results();
        $display("covered %0d loads (%0d dropped), %0d runs, %0d merged beats checked",
                 sb.loads, sb.ignored, sb.runs, sb.checked);
        $display("sender held for %0d full drains, %0d errors", drains, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
sv/tswm_pkg.sv
sv/three_way_sorted_merge.sv
verif/tb_three_way_sorted_merge.sv
